### design/mhd_pkg.sv
// Shared types, codes and helpers for the message header deframer.
package mhd_pkg;

  // Kind of one result word
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ROUTE  = 2'd1,
    KIND_BODY   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_TYPE   = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;

  // Message types
  localparam logic [1:0] TYPE_REQUEST  = 2'd0;
  localparam logic [1:0] TYPE_NOTIFY   = 2'd1;
  localparam logic [1:0] TYPE_RESPONSE = 2'd2;
  localparam logic [1:0] TYPE_PUSH     = 2'd3;

  // Base-128 id: payload bits per byte and bytes that add to the id
  localparam int ID_BYTE_BITS = 7;
  localparam int MAX_ID_BYTES = 7;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [31:0] msg_id;
    logic [1:0]  msg_type;
    logic        route_is_code;
    logic [15:0] route_num;
    logic [7:0]  route_length;
    logic        body_gzipped;
    logic        error_flag;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  // Up to two result words produced by one input word
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Build a route, body or error word; header fields stay zero
  function automatic result_t make_simple(kind_t k, logic [7:0] b, logic [1:0] code,
                                          logic is_last);
    result_t r;
    r = '0;
    r.kind       = k;
    r.out_byte   = b;
    r.error_code = code;
    r.last       = is_last;
    return r;
  endfunction

endpackage

### design/message_header_deframer_unit.sv
// Message header deframer top level: input register, parser and result queue.
//
// Usage:
//   Input channel (data_valid/data_ready) takes one frame word per cycle
//   while ready: data_byte and frame_last, set on the final frame byte.
//   Result channel (result_valid/result_ready) returns header, route, body
//   and error words with last marking the end of each message.
//   cfg_write/cfg_data load notify_id, the id shown for notify and push
//   headers; write it only while the block is idle.
// Timing:
//   A word is registered on acceptance and parsed, once the queue has room,
//   into a four-entry result queue, from which its first result is offered.
//   One word is taken per cycle while the queue keeps room, limited by the
//   single parse stage; a route byte that ends a frame early gives two
//   results, which leave the queue one after the other.
// Reset:
//   rst (synchronous) empties the queue, clears notify_id and waits for a
//   flag byte. When the receiver stalls, the queue fills and data_ready
//   drops while a word waits in the input register and fewer than two
//   queue entries are free.
module message_header_deframer_unit
  import mhd_pkg::*;
#(
  parameter int ID_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [31:0] msg_id,
  output logic [1:0]  msg_type,
  output logic        route_is_code,
  output logic [15:0] route_num,
  output logic [7:0]  route_length,
  output logic        body_gzipped,
  output logic        error_flag,
  output logic [1:0]  error_code,
  output logic        last
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;
  logic       room;
  logic       advance;
  push_t      push;
  result_t    head;

  assign advance    = stage_valid && room;
  assign data_ready = !stage_valid || room;

  // Hold the accepted word until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (data_valid && data_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      stage_byte <= data_byte;
      stage_last <= frame_last;
    end
  end

  mhd_parser #(
    .ID_WIDTH (ID_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_fire   (advance),
    .in_byte   (stage_byte),
    .in_last   (stage_last),
    .push      (push)
  );

  mhd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (result_valid && result_ready),
    .head      (head),
    .not_empty (result_valid),
    .room      (room)
  );

  // Drive the result ports from the queue head
  assign kind          = head.kind;
  assign out_byte      = head.out_byte;
  assign msg_id        = head.msg_id;
  assign msg_type      = head.msg_type;
  assign route_is_code = head.route_is_code;
  assign route_num     = head.route_num;
  assign route_length  = head.route_length;
  assign body_gzipped  = head.body_gzipped;
  assign error_flag    = head.error_flag;
  assign error_code    = head.error_code;
  assign last          = head.last;

endmodule

### design/mhd_parser.sv
// Frame parser: per-word state update and result generation.
module mhd_parser
  import mhd_pkg::*;
#(
  parameter int ID_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_fire,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output push_t       push
);

  typedef enum logic [2:0] {
    PH_FLAG = 3'd0,
    PH_ID   = 3'd1,
    PH_RCHI = 3'd2,
    PH_RCLO = 3'd3,
    PH_RLEN = 3'd4,
    PH_RSTR = 3'd5,
    PH_BODY = 3'd6
  } phase_t;

  phase_t                phase, phase_next;
  logic [5:0]            flag_bits, flag_bits_next;
  logic [ID_WIDTH-1:0]   id_accum, id_accum_next;
  logic [2:0]            id_shift, id_shift_next;
  logic [15:0]           route_num_reg, route_num_reg_next;
  logic [7:0]            route_remaining, route_remaining_next;
  logic                  drop_until_end, drop_until_end_next;
  logic [31:0]           notify_id;

  logic [1:0]            typ;
  logic                  routed;
  logic                  as_code;
  logic [5:0]            id_sh;
  logic [63:0]           id_wide;
  logic [ID_WIDTH-1:0]   id_sum;
  logic [63:0]           id_ext;
  logic                  emit_header;
  logic                  header_last;
  logic [7:0]            rr_dec;
  result_t               hdr;

  // Decode the word against the current phase
  always_comb begin
    phase_next           = phase;
    flag_bits_next       = flag_bits;
    id_accum_next        = id_accum;
    id_shift_next        = id_shift;
    route_num_reg_next   = route_num_reg;
    route_remaining_next = route_remaining;
    drop_until_end_next  = drop_until_end;
    push                 = '0;
    emit_header          = 1'b0;
    header_last          = 1'b0;

    typ     = flag_bits[2:1];
    routed  = (typ != TYPE_RESPONSE);
    as_code = routed & flag_bits[0];

    // Shift the 7 payload bits into place: 7 * id_shift
    id_sh   = {id_shift, 3'b000} - 6'(id_shift);
    id_wide = 64'(in_byte[ID_BYTE_BITS-1:0]) << id_sh;
    id_sum  = id_accum + id_wide[ID_WIDTH-1:0];
    rr_dec  = (route_remaining != 8'd0) ? route_remaining - 8'd1 : route_remaining;

    if (in_fire) begin
      if (drop_until_end) begin
        // Skip the rest of a rejected frame
        if (in_last) begin
          drop_until_end_next = 1'b0;
          phase_next          = PH_FLAG;
        end
      end else begin
        case (phase)
          PH_FLAG: begin
            flag_bits_next       = in_byte[5:0];
            id_accum_next        = '0;
            id_shift_next        = '0;
            route_num_reg_next   = '0;
            route_remaining_next = '0;
            if (in_byte[3]) begin
              push.count          = 2'd1;
              push.first          = make_simple(KIND_ERROR, 8'd0, ERR_TYPE, 1'b1);
              drop_until_end_next = !in_last;
            end else if (in_last) begin
              push.count = 2'd1;
              push.first = make_simple(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
            end else if (!in_byte[1]) begin
              phase_next = PH_ID;
            end else begin
              phase_next = in_byte[0] ? PH_RCHI : PH_RLEN;
            end
          end
          PH_ID: begin
            if (id_shift < 3'(MAX_ID_BYTES)) begin
              id_accum_next = id_sum;
              id_shift_next = id_shift + 3'd1;
            end
            if (in_byte[7]) begin
              if (in_last) begin
                push.count = 2'd1;
                push.first = make_simple(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
                phase_next = PH_FLAG;
              end
            end else if (typ == TYPE_RESPONSE) begin
              emit_header = 1'b1;
              header_last = in_last;
              phase_next  = in_last ? PH_FLAG : PH_BODY;
            end else if (in_last) begin
              push.count = 2'd1;
              push.first = make_simple(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
              phase_next = PH_FLAG;
            end else begin
              phase_next = flag_bits[0] ? PH_RCHI : PH_RLEN;
            end
          end
          PH_RCHI: begin
            route_num_reg_next = {in_byte, 8'd0};
            if (in_last) begin
              push.count = 2'd1;
              push.first = make_simple(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
              phase_next = PH_FLAG;
            end else begin
              phase_next = PH_RCLO;
            end
          end
          PH_RCLO: begin
            route_num_reg_next = route_num_reg | {8'd0, in_byte};
            emit_header        = 1'b1;
            header_last        = in_last;
            phase_next         = in_last ? PH_FLAG : PH_BODY;
          end
          PH_RLEN: begin
            route_remaining_next = in_byte;
            if (in_last && in_byte != 8'd0) begin
              push.count = 2'd1;
              push.first = make_simple(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
              phase_next = PH_FLAG;
            end else begin
              emit_header = 1'b1;
              header_last = in_last;
              if (in_last) begin
                phase_next = PH_FLAG;
              end else begin
                phase_next = (in_byte != 8'd0) ? PH_RSTR : PH_BODY;
              end
            end
          end
          PH_RSTR: begin
            route_remaining_next = rr_dec;
            if (in_last && rr_dec != 8'd0) begin
              // Route cut short: pass the byte, then flag the length error
              push.count  = 2'd2;
              push.first  = make_simple(KIND_ROUTE, in_byte, ERR_NONE, 1'b0);
              push.second = make_simple(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
              phase_next  = PH_FLAG;
            end else begin
              push.count = 2'd1;
              push.first = make_simple(KIND_ROUTE, in_byte, ERR_NONE, in_last);
              if (in_last) begin
                phase_next = PH_FLAG;
              end else begin
                phase_next = (rr_dec == 8'd0) ? PH_BODY : PH_RSTR;
              end
            end
          end
          PH_BODY: begin
            push.count = 2'd1;
            push.first = make_simple(KIND_BODY, in_byte, ERR_NONE, in_last);
            if (in_last) begin
              phase_next = PH_FLAG;
            end
          end
          default: begin
            phase_next = PH_FLAG;
          end
        endcase
      end
    end

    // Header word built from the updated id and route fields
    id_ext                = 64'(id_accum_next);
    hdr                   = '0;
    hdr.kind              = KIND_HEADER;
    hdr.msg_id            = (typ == TYPE_REQUEST || typ == TYPE_RESPONSE) ?
                            id_ext[31:0] : notify_id;
    hdr.msg_type          = typ;
    hdr.route_is_code     = as_code;
    hdr.route_num         = as_code ? route_num_reg_next : 16'd0;
    hdr.route_length      = (routed && !as_code) ? route_remaining_next : 8'd0;
    hdr.body_gzipped      = flag_bits[4];
    hdr.error_flag        = flag_bits[5];
    hdr.last              = header_last;
    if (emit_header) begin
      push.count = 2'd1;
      push.first = hdr;
    end
  end

  // Hold parse state and the notify id register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FLAG;
      flag_bits       <= '0;
      id_accum        <= '0;
      id_shift        <= '0;
      route_num_reg   <= '0;
      route_remaining <= '0;
      drop_until_end  <= 1'b0;
      notify_id       <= '0;
    end else begin
      phase           <= phase_next;
      flag_bits       <= flag_bits_next;
      id_accum        <= id_accum_next;
      id_shift        <= id_shift_next;
      route_num_reg   <= route_num_reg_next;
      route_remaining <= route_remaining_next;
      drop_until_end  <= drop_until_end_next;
      if (cfg_write) begin
        notify_id <= cfg_data;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A dropped frame produces no words
  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && drop_until_end) |-> push.count == 2'd0)
    else $error("word emitted while dropping frame");

  // A second word is only ever the truncated-route error
  a_second_error: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.second.kind == KIND_ERROR &&
                              push.second.error_code == ERR_LENGTH &&
                              push.first.kind == KIND_ROUTE))
    else $error("unexpected second word");

  // Every error word closes its message
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd1 && push.first.kind == KIND_ERROR) |-> push.first.last)
    else $error("error word without last");
`endif

endmodule

### design/mhd_result_fifo.sv
// Result queue: takes up to two words per cycle, releases one.
module mhd_result_fifo
  import mhd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output result_t head,
  output logic    not_empty,
  output logic    room
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic [FIFO_AW:0]   count_next;

  assign head       = mem[rd_ptr];
  assign not_empty  = (count != '0);
  // Room for the worst case of two words from one input word
  assign room       = (count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign count_next = count + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);

  // Write the incoming words
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Never push past the queue depth
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ((FIFO_AW+2)'(count) + (FIFO_AW+2)'(push.count)) <=
    ((FIFO_AW+2)'(FIFO_DEPTH) + (FIFO_AW+2)'(pop)))
    else $error("result queue overflow");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for the message header deframer: directed table, random frames.
module testbench;
  import mhd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int CHUNK_WORDS   = 100;
  localparam int ID_BYTES_USED = 7;

  typedef enum logic [2:0] {
    P_FLAG, P_ID, P_RCHI, P_RCLO, P_RLEN, P_RSTR, P_BODY
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
  } word_t;

  // One directed row: frame word plus the error code read straight off it
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic [1:0] err;
  } row_t;

  localparam row_t DIRECTED [25] = '{
    {8'h08, 1'b1, ERR_TYPE},    // unknown type on a one-byte frame
    {8'h0E, 1'b0, ERR_TYPE},    // unknown type, rest of frame dropped
    {8'hFF, 1'b0, ERR_NONE},
    {8'h00, 1'b1, ERR_NONE},
    {8'h00, 1'b1, ERR_LENGTH},  // frame ends on the flag byte
    {8'h21, 1'b0, ERR_NONE},    // request, coded route, error bit
    {8'hFF, 1'b0, ERR_NONE},
    {8'hFF, 1'b0, ERR_NONE},
    {8'h7F, 1'b0, ERR_NONE},
    {8'hFF, 1'b0, ERR_NONE},
    {8'hFF, 1'b0, ERR_NONE},
    {8'h00, 1'b0, ERR_NONE},
    {8'hFF, 1'b1, ERR_NONE},
    {8'h14, 1'b0, ERR_NONE},    // gzipped response
    {8'h80, 1'b1, ERR_LENGTH},  // frame ends on an unterminated id
    {8'h03, 1'b0, ERR_NONE},    // notify, coded route
    {8'hAB, 1'b1, ERR_LENGTH},  // frame ends before the low code byte
    {8'h06, 1'b0, ERR_NONE},    // push, route string
    {8'h03, 1'b0, ERR_NONE},
    {8'h41, 1'b0, ERR_NONE},
    {8'h42, 1'b1, ERR_NONE},    // route string cut short: byte plus error
    {8'h06, 1'b0, ERR_NONE},
    {8'h00, 1'b1, ERR_NONE},    // empty route, empty body
    {8'h04, 1'b0, ERR_NONE},
    {8'h00, 1'b1, ERR_NONE}     // response with empty body
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte = '0;
  logic        frame_last = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] msg_id;
  logic [1:0]  msg_type;
  logic        route_is_code;
  logic [15:0] route_num;
  logic [7:0]  route_length;
  logic        body_gzipped;
  logic        error_flag;
  logic [1:0]  error_code;
  logic        last;

  message_header_deframer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .data_valid    (data_valid),
    .data_ready    (data_ready),
    .data_byte     (data_byte),
    .frame_last    (frame_last),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .kind          (kind),
    .out_byte      (out_byte),
    .msg_id        (msg_id),
    .msg_type      (msg_type),
    .route_is_code (route_is_code),
    .route_num     (route_num),
    .route_length  (route_length),
    .body_gzipped  (body_gzipped),
    .error_flag    (error_flag),
    .error_code    (error_code),
    .last          (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Parser state mirrored by the predictor
  parse_phase_t phase_q;
  logic [5:0]   flags_q;
  logic [31:0]  id_acc_q;
  logic [2:0]   id_cnt_q;
  logic [15:0]  code_q;
  logic [7:0]   remain_q;
  logic         dropping_q;
  logic [31:0]  notify_q;

  result_t pending_results [$];
  word_t   stim_words [$];
  result_t want;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  logic    no_idle = 1'b0;

  function automatic logic idle_roll();
    return !no_idle && ($urandom_range(0, 99) < 26);
  endfunction

  function automatic result_t plain_word(kind_t k, logic [7:0] b, logic [1:0] code,
                                         logic lst);
    result_t r;
    r            = '0;
    r.kind       = k;
    r.out_byte   = b;
    r.error_code = code;
    r.last       = lst;
    return r;
  endfunction

  // Build the header word from the parsed flags, id and route
  function automatic result_t header_word(logic lst);
    result_t    r;
    logic [1:0] t;
    logic       routed;
    logic       as_code;
    t       = flags_q[2:1];
    routed  = (t != TYPE_RESPONSE);
    as_code = routed && flags_q[0];
    r                = '0;
    r.kind           = KIND_HEADER;
    r.msg_id         = (t == TYPE_REQUEST || t == TYPE_RESPONSE) ? id_acc_q : notify_q;
    r.msg_type       = t;
    r.route_is_code  = as_code;
    r.route_num      = as_code ? code_q : 16'd0;
    r.route_length   = (routed && !as_code) ? remain_q : 8'd0;
    r.body_gzipped   = flags_q[4];
    r.error_flag     = flags_q[5];
    r.last           = lst;
    return r;
  endfunction

  function automatic parse_phase_t route_start();
    return flags_q[0] ? P_RCHI : P_RLEN;
  endfunction

  task automatic clear_parser();
    phase_q    = P_FLAG;
    flags_q    = '0;
    id_acc_q   = '0;
    id_cnt_q   = '0;
    code_q     = '0;
    remain_q   = '0;
    dropping_q = 1'b0;
    notify_q   = '0;
  endtask

  // Advance the predicted parser by one frame word, return up to two results
  task automatic parse_word(input logic [7:0] b, input logic fl, output int n,
                            output result_t r0, output result_t r1);
    logic [63:0] part;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (dropping_q) begin
      if (fl) begin
        dropping_q = 1'b0;
        phase_q    = P_FLAG;
      end
    end else begin
      case (phase_q)
        P_FLAG: begin
          flags_q  = b[5:0];
          id_acc_q = '0;
          id_cnt_q = '0;
          code_q   = '0;
          remain_q = '0;
          if (b[3]) begin
            r0 = plain_word(KIND_ERROR, 8'd0, ERR_TYPE, 1'b1);
            n  = 1;
            if (!fl) dropping_q = 1'b1;
          end else if (fl) begin
            r0 = plain_word(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
            n  = 1;
          end else if (b[2:1] == TYPE_REQUEST || b[2:1] == TYPE_RESPONSE) begin
            phase_q = P_ID;
          end else begin
            phase_q = route_start();
          end
        end
        P_ID: begin
          if (id_cnt_q < ID_BYTES_USED) begin
            part     = {57'd0, b[6:0]} << (7 * id_cnt_q);
            id_acc_q = id_acc_q + part[31:0];
            id_cnt_q = id_cnt_q + 3'd1;
          end
          if (b[7]) begin
            if (fl) begin
              r0      = plain_word(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
              n       = 1;
              phase_q = P_FLAG;
            end
          end else if (flags_q[2:1] == TYPE_RESPONSE) begin
            r0      = header_word(fl);
            n       = 1;
            phase_q = fl ? P_FLAG : P_BODY;
          end else if (fl) begin
            r0      = plain_word(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
            n       = 1;
            phase_q = P_FLAG;
          end else begin
            phase_q = route_start();
          end
        end
        P_RCHI: begin
          code_q = {b, 8'd0};
          if (fl) begin
            r0      = plain_word(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
            n       = 1;
            phase_q = P_FLAG;
          end else begin
            phase_q = P_RCLO;
          end
        end
        P_RCLO: begin
          code_q  = code_q | {8'd0, b};
          r0      = header_word(fl);
          n       = 1;
          phase_q = fl ? P_FLAG : P_BODY;
        end
        P_RLEN: begin
          remain_q = b;
          n        = 1;
          if (fl && b != 8'd0) begin
            r0      = plain_word(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
            phase_q = P_FLAG;
          end else begin
            r0      = header_word(fl);
            phase_q = fl ? P_FLAG : (b != 8'd0 ? P_RSTR : P_BODY);
          end
        end
        P_RSTR: begin
          if (remain_q > 8'd0) remain_q = remain_q - 8'd1;
          if (fl && remain_q != 8'd0) begin
            r0      = plain_word(KIND_ROUTE, b, ERR_NONE, 1'b0);
            r1      = plain_word(KIND_ERROR, 8'd0, ERR_LENGTH, 1'b1);
            n       = 2;
            phase_q = P_FLAG;
          end else begin
            r0      = plain_word(KIND_ROUTE, b, ERR_NONE, fl);
            n       = 1;
            phase_q = fl ? P_FLAG : (remain_q == 8'd0 ? P_BODY : P_RSTR);
          end
        end
        P_BODY: begin
          r0 = plain_word(KIND_BODY, b, ERR_NONE, fl);
          n  = 1;
          if (fl) phase_q = P_FLAG;
        end
        default: phase_q = P_FLAG;
      endcase
    end
  endtask

  // Offer one word at a falling edge, hold it until accepted, queue its results
  task automatic send_word(word_t w, logic [1:0] lit_err);
    int      n;
    result_t r0;
    result_t r1;
    while (idle_roll()) begin
      data_valid <= 1'b0;
      @(negedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= w.b;
    frame_last <= w.l;
    do @(posedge clk); while (!data_ready);
    parse_word(w.b, w.l, n, r0, r1);
    if (lit_err != ERR_NONE) begin
      pending_results.push_back(plain_word(KIND_ERROR, 8'd0, lit_err, 1'b1));
    end else begin
      if (n > 0) pending_results.push_back(r0);
      if (n > 1) pending_results.push_back(r1);
    end
    @(negedge clk);
  endtask

  // Drain, let the parser settle, then load notify_id
  task automatic load_notify(logic [31:0] value);
    data_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    notify_q = value;
  endtask

  // Append one random frame: mostly well-formed, some noise, some cut short
  task automatic add_frame();
    word_t      f [$];
    int         sel;
    int         n;
    int         cut;
    int         i;
    logic [1:0] t;
    logic [7:0] flag;
    logic [7:0] len;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) f.push_back({8'($urandom), 1'b0});
    end else if (sel < 16) begin
      flag    = 8'($urandom);
      flag[3] = 1'b1;
      f.push_back({flag, 1'b0});
      n = $urandom_range(0, 4);
      repeat (n) f.push_back({8'($urandom), 1'b0});
    end else begin
      t         = 2'($urandom_range(0, 3));
      flag      = 8'($urandom);
      flag[3]   = 1'b0;
      flag[2:1] = t;
      f.push_back({flag, 1'b0});
      if (t == TYPE_REQUEST || t == TYPE_RESPONSE) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
        for (i = 0; i < n; i++) f.push_back({(i < n - 1), 7'($urandom), 1'b0});
      end
      if (t != TYPE_RESPONSE) begin
        if (flag[0]) begin
          repeat (2) f.push_back({8'($urandom), 1'b0});
        end else begin
          len = ($urandom_range(0, 59) == 0) ? 8'd255 : 8'($urandom_range(0, 5));
          f.push_back({len, 1'b0});
          repeat (len) f.push_back({8'($urandom), 1'b0});
        end
      end
      n = $urandom_range(0, 8);
      repeat (n) f.push_back({8'($urandom), 1'b0});
      if ($urandom_range(0, 99) < 15) begin
        cut = $urandom_range(1, f.size());
        while (f.size() > cut) void'(f.pop_back());
      end
    end
    f[f.size() - 1].l = 1'b1;
    foreach (f[k]) stim_words.push_back(f[k]);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    result_ready <= rst ? 1'b0 : !idle_roll();
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: expected no result, actual kind %0d byte %0h", $time, kind, out_byte);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
        check_field("msg_id", want.msg_id, msg_id);
        check_field("msg_type", 32'(want.msg_type), 32'(msg_type));
        check_field("route_is_code", 32'(want.route_is_code), 32'(route_is_code));
        check_field("route_num", 32'(want.route_num), 32'(route_num));
        check_field("route_length", 32'(want.route_length), 32'(route_length));
        check_field("body_gzipped", 32'(want.body_gzipped), 32'(body_gzipped));
        check_field("error_flag", 32'(want.error_flag), 32'(error_flag));
        check_field("error_code", 32'(want.error_code), 32'(error_code));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((data_valid && data_ready) || (result_valid && result_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    clear_parser();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    load_notify($urandom);
    foreach (DIRECTED[i]) send_word({DIRECTED[i].b, DIRECTED[i].l}, DIRECTED[i].err);

    // Random frames, one notify_id setting per chunk; one chunk runs without idling
    for (int chunk = 0; chunk < 4; chunk++) begin
      case (chunk)
        0:       load_notify(32'h0000_0000);
        1:       load_notify(32'hFFFF_FFFF);
        default: load_notify($urandom);
      endcase
      no_idle = (chunk == 2);
      while (stim_words.size() < CHUNK_WORDS) add_frame();
      while (stim_words.size() != 0) send_word(stim_words.pop_front(), ERR_NONE);
    end
    data_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain and let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
